// ----- rtl/xcr_pkg.sv -----
// shared types, constants and crc function for the xmodem crc receiver
`timescale 1ns / 1ps
package xcr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int IDX_W       = 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QLVL_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0]  B_SOH   = 8'h01;
  localparam logic [7:0]  B_EOT   = 8'h04;
  localparam logic [7:0]  B_ACK   = 8'h06;
  localparam logic [7:0]  B_NAK   = 8'h15;
  localparam logic [7:0]  B_C     = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd4;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR  = 3'd1,
    PH_BLK  = 3'd2,
    PH_CMP  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRCH = 3'd5,
    PH_CRCL = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    PS_NONE = 2'd0,
    PS_GOOD = 2'd1,
    PS_BAD  = 2'd2
  } pkt_status_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [6:0]  data_index;
    logic [1:0]  packet_status;
    logic        transfer_done;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } resp_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/xcr_core.sv -----
// protocol state machine: crc check, block parsing and reply generation
`timescale 1ns / 1ps
module xcr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  xcr_pkg::action_t  action,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        timeout_ticks,
  output xcr_pkg::resp_t    resp
);
  import xcr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        eot_r, eot_nxt;
  logic              first_r, first_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crch_r, crch_nxt;
  logic [7:0]        idle_r, idle_nxt;

  logic [7:0]  idle_inc;
  logic [7:0]  lim;
  logic        tick_live;
  logic        timeout_hit;
  logic        crc_ok;
  logic        done_nxt;
  result_t     rc;

  assign idle_inc    = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;
  assign lim         = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
  assign tick_live   = (phase_r != PH_IDLE) && (eot_r != 2'd2);
  assign timeout_hit = idle_inc >= lim;
  assign crc_ok      = ({crch_r, rx_byte} == crc_r);
  assign done_nxt    = (eot_nxt == 2'd2);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    eot_nxt   = eot_r;
    first_nxt = first_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    crch_nxt  = crch_r;
    idle_nxt  = idle_r;
    if (fire) begin
      case (action)
        ACT_START: begin
          phase_nxt = PH_HDR;
          eot_nxt   = 2'd0;
          first_nxt = 1'b0;
          idx_nxt   = '0;
          crc_nxt   = '0;
          crch_nxt  = '0;
          idle_nxt  = '0;
        end
        ACT_TICK: begin
          if (tick_live) begin
            if (timeout_hit) begin
              idle_nxt  = '0;
              phase_nxt = PH_HDR;
              idx_nxt   = '0;
            end else begin
              idle_nxt = idle_inc;
            end
          end
        end
        ACT_BYTE: begin
          if (phase_r != PH_IDLE) begin
            idle_nxt = '0;
            case (phase_r)
              PH_HDR: begin
                if (rx_byte == B_SOH) begin
                  phase_nxt = PH_BLK;
                end else if (rx_byte == B_EOT) begin
                  eot_nxt = (eot_r == 2'd0) ? 2'd1 : 2'd2;
                end
              end
              PH_BLK: phase_nxt = PH_CMP;
              PH_CMP: begin
                phase_nxt = PH_DATA;
                idx_nxt   = '0;
                crc_nxt   = '0;
              end
              PH_DATA: begin
                crc_nxt = crc_step(crc_r, rx_byte);
                idx_nxt = idx_r + IDX_W'(1);
                if (idx_nxt >= IDX_W'(BLOCK_BYTES)) begin
                  phase_nxt = PH_CRCH;
                end
              end
              PH_CRCH: begin
                crch_nxt  = rx_byte;
                phase_nxt = PH_CRCL;
              end
              PH_CRCL: begin
                phase_nxt = PH_HDR;
                idx_nxt   = '0;
                if (crc_ok) begin
                  first_nxt = 1'b1;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // replies
  always_comb begin
    rc               = '0;
    rc.send_valid    = 1'b1;
    rc.transfer_done = done_nxt;
    rc.last          = 1'b1;
    resp             = '0;
    resp.r0          = rc;
    resp.r1          = rc;
    resp.r1.send_byte = B_C;
    if (fire) begin
      case (action)
        ACT_START: begin
          resp.count        = 2'd1;
          resp.r0.send_byte = B_C;
        end
        ACT_TICK: begin
          if (tick_live && timeout_hit) begin
            resp.count        = 2'd1;
            resp.r0.send_byte = first_r ? B_NAK : B_C;
          end
        end
        ACT_BYTE: begin
          case (phase_r)
            PH_HDR: begin
              if (rx_byte == B_EOT) begin
                if (eot_r == 2'd0) begin
                  resp.count        = 2'd1;
                  resp.r0.send_byte = B_NAK;
                end else if (eot_r == 2'd1) begin
                  resp.count        = 2'd2;
                  resp.r0.send_byte = B_ACK;
                  resp.r0.last      = 1'b0;
                end else begin
                  resp.count        = 2'd1;
                  resp.r0.send_byte = B_ACK;
                end
              end else if (rx_byte != B_SOH) begin
                resp.count        = 2'd1;
                resp.r0.send_byte = B_NAK;
              end
            end
            PH_DATA: begin
              resp.count         = 2'd1;
              resp.r0.send_valid = 1'b0;
              resp.r0.data_valid = 1'b1;
              resp.r0.data_byte  = rx_byte;
              resp.r0.data_index = idx_r[6:0];
            end
            PH_CRCL: begin
              resp.count            = 2'd1;
              resp.r0.send_byte     = crc_ok ? B_ACK : B_NAK;
              resp.r0.packet_status = crc_ok ? PS_GOOD : PS_BAD;
            end
            default: resp.count = 2'd0;
          endcase
        end
        default: resp.count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      eot_r   <= '0;
      first_r <= 1'b0;
      idx_r   <= '0;
      crc_r   <= '0;
      crch_r  <= '0;
      idle_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      eot_r   <= eot_nxt;
      first_r <= first_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      crch_r  <= crch_nxt;
      idle_r  <= idle_nxt;
    end
  end

endmodule

// ----- rtl/xcr_fifo.sv -----
// result queue taking up to two entries per cycle, giving one per cycle while pop is high
`timescale 1ns / 1ps
module xcr_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xcr_pkg::resp_t              push,
  input  logic                        pop,
  output xcr_pkg::result_t            head,
  output logic                        not_empty,
  output logic [xcr_pkg::QLVL_W-1:0]  level
);
  import xcr_pkg::*;

  result_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QLVL_W-1:0]   lvl_r, lvl_nxt;
  logic                do_pop;

  assign do_pop    = pop && (lvl_r != '0);
  assign not_empty = (lvl_r != '0);
  assign level     = lvl_r;
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + QPTR_W'(push.count);
    rp_nxt  = do_pop ? rp_r + QPTR_W'(1) : rp_r;
    lvl_nxt = lvl_r + QLVL_W'(push.count) - QLVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wp_r + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

// ----- rtl/xmodem_crc_receiver.sv -----
// top level of the xmodem crc receiver: input register, config register, core and queue
`timescale 1ns / 1ps
// Usage:
//   input channel: in_valid/in_ready with in_action (start, received byte, slow tick)
//   and in_rx_byte. Every action is one transfer; bytes and ticks share the channel.
//   output channel: out_valid/out_ready, one reply or payload byte per transfer;
//   out_last marks the final result of one input transfer.
//   cfg_wr_en/cfg_wr_data write the timeout in slow ticks; the user must write it
//   only while the block is idle; the block does not enforce this.
// Path: input register, then core, then result queue, which drives the output channel.
// Throughput: one input transfer per cycle while each gives at most one result and
//   out_ready stays high; the EOT that completes the handshake gives ACK then 'C',
//   two results. The four-entry result queue sets this: the core takes an item only
//   while at least two entries are free.
// Reset: timeout back to 4 ticks, protocol idle, queue empty; nothing is sent
//   until a start transfer arrives.
// Stall: with out_ready low the queue fills, the core holds the item in the input
//   register and in_ready drops; no result is lost or repeated.
module xmodem_crc_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_data_index,
  output logic [1:0]  out_packet_status,
  output logic        out_transfer_done,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import xcr_pkg::*;

  logic              in_v_r, in_v_nxt;
  logic [1:0]        act_r;
  logic [7:0]        byte_r;
  logic [7:0]        timeout_r;
  logic              in_take;
  logic              proc_fire;
  logic [QLVL_W-1:0] level;
  resp_t             resp;
  result_t           head;

  assign proc_fire = in_v_r && (level <= QLVL_W'(QDEPTH - 2));
  assign in_ready  = !in_v_r || proc_fire;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (proc_fire) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r  <= in_action;
      byte_r <= in_rx_byte;
    end
  end

  xcr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (proc_fire),
    .action        (action_t'(act_r)),
    .rx_byte       (byte_r),
    .timeout_ticks (timeout_r),
    .resp          (resp)
  );

  xcr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (resp),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .level     (level)
  );

  assign out_send_valid    = head.send_valid;
  assign out_send_byte     = head.send_byte;
  assign out_data_valid    = head.data_valid;
  assign out_data_byte     = head.data_byte;
  assign out_data_index    = head.data_index;
  assign out_packet_status = head.packet_status;
  assign out_transfer_done = head.transfer_done;
  assign out_last          = head.last;

  // queue never overflows
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= QLVL_W'(QDEPTH))
    else $error("result queue overflow");

  // a result without last always has its companion already queued
  a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (level >= QLVL_W'(2)))
    else $error("first of a result pair without its follower");

  // a pair push leaves the output channel valid next cycle
  a_pair_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && resp.count == 2'd2) |=> out_valid)
    else $error("result pair lost");

  // the input side stalls only while an item waits in the input register
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && level > QLVL_W'(QDEPTH - 2)))
    else $error("input stalled without cause");

endmodule
